[design/ihlp_pkg.sv]
// Package for the IPv4 L4 header-length parser: verdict codes, header constants
// and the per-frame record passed from the front end to the back end.
// No dependencies.
package ihlp_pkg;

	localparam int unsigned FIFO_DEPTH_DEF = 4;

	localparam logic [15:0] ETH_BYTES  = 16'd14;
	localparam logic [15:0] POS_IHL    = 16'd14;
	localparam logic [15:0] POS_LEN_HI = 16'd16;
	localparam logic [15:0] POS_LEN_LO = 16'd17;
	localparam logic [15:0] POS_PROTO  = 16'd23;
	localparam logic [15:0] MIN_PROTO  = 16'd24;
	localparam logic [15:0] COUNT_MAX  = 16'hffff;
	localparam logic [6:0]  TCP_OFF    = 7'd26;
	localparam logic [3:0]  MIN_WORDS  = 4'd5;
	localparam logic [6:0]  UDP_BYTES  = 7'd8;
	localparam logic [7:0]  PROTO_TCP  = 8'd6;
	localparam logic [7:0]  PROTO_UDP  = 8'd17;

	typedef enum logic [2:0] {
		VERDICT_KEEP      = 3'd0,
		VERDICT_IP_SHORT  = 3'd1,
		VERDICT_TCP_SHORT = 3'd2,
		VERDICT_PROTO     = 3'd3,
		VERDICT_NO_PAY    = 3'd4,
		VERDICT_TRUNC     = 3'd5
	} verdict_t;

	typedef struct packed {
		logic [15:0] cap;
		logic [3:0]  ihl;
		logic [15:0] total;
		logic [7:0]  proto;
		logic [3:0]  tcp;
	} frame_rec_t;

endpackage

[design/ihlp_front.sv]
// Front end of the IPv4 L4 header-length parser: counts frame bytes and
// captures header fields; emits one frame record at the last byte.
// Depends on ihlp_pkg.
module ihlp_front import ihlp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       push,
	output frame_rec_t push_rec,
	input  logic       full
);

	logic [15:0] byte_count_q;
	logic [3:0]  ihl_q;
	logic [15:0] total_q;
	logic [7:0]  proto_q;
	logic [3:0]  tcp_q;

	logic [3:0]  ihl_nx;
	logic [15:0] total_nx;
	logic [7:0]  proto_nx;
	logic [3:0]  tcp_nx;
	logic [6:0]  tcp_pos;
	logic [15:0] cap;
	logic        accept;

	assign in_ready = !full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		ihl_nx   = ihl_q;
		total_nx = total_q;
		proto_nx = proto_q;
		tcp_nx   = tcp_q;
		if (byte_count_q == POS_IHL) begin
			ihl_nx = in_byte[3:0];
		end else if (byte_count_q == POS_LEN_HI) begin
			total_nx = {in_byte, total_q[7:0]};
		end else if (byte_count_q == POS_LEN_LO) begin
			total_nx = {total_q[15:8], in_byte};
		end else if (byte_count_q == POS_PROTO) begin
			proto_nx = in_byte;
		end
		tcp_pos = TCP_OFF + {1'b0, ihl_nx, 2'b00};
		if (byte_count_q > POS_IHL && byte_count_q == {9'd0, tcp_pos}) begin
			tcp_nx = in_byte[7:4];
		end
		cap = (byte_count_q < COUNT_MAX) ? byte_count_q + 16'd1 : COUNT_MAX;
	end

	assign push           = accept && in_last;
	assign push_rec.cap   = cap;
	assign push_rec.ihl   = ihl_nx;
	assign push_rec.total = total_nx;
	assign push_rec.proto = proto_nx;
	assign push_rec.tcp   = tcp_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			ihl_q        <= '0;
			total_q      <= '0;
			proto_q      <= '0;
			tcp_q        <= '0;
		end else if (accept) begin
			if (in_last) begin
				byte_count_q <= '0;
				ihl_q        <= '0;
				total_q      <= '0;
				proto_q      <= '0;
				tcp_q        <= '0;
			end else begin
				byte_count_q <= cap;
				ihl_q        <= ihl_nx;
				total_q      <= total_nx;
				proto_q      <= proto_nx;
				tcp_q        <= tcp_nx;
			end
		end
	end

endmodule

[design/ihlp_fifo.sv]
// Short queue of frame records between front and back end of the parser.
// Depends on ihlp_pkg.
module ihlp_fifo import ihlp_pkg::*; #(
	parameter int unsigned DEPTH = FIFO_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  frame_rec_t push_rec,
	output logic       full,
	input  logic       pop,
	output frame_rec_t pop_rec,
	output logic       empty
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	frame_rec_t    mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign pop_rec = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_IDX) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + PW'(1);
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[design/ihlp_back.sv]
// Back end of the parser: verdict and lengths in stage 1, pad and trim into
// the output register in stage 2. Depends on ihlp_pkg.
module ihlp_back import ihlp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        empty,
	input  frame_rec_t  rec,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [79:0] out_data,
	output logic [2:0]  out_user
);

	logic        valid_s1;
	verdict_t    verdict_s1;
	logic [7:0]  hdr_s1;
	logic [15:0] pay_s1;
	logic [16:0] rest_s1;
	logic [15:0] cap_s1;

	logic        valid_s2;
	verdict_t    verdict_s2;
	logic [7:0]  hdr_s2;
	logic [15:0] pay_s2;
	logic [16:0] rest_s2;
	logic [15:0] cap_s2;
	logic [16:0] pad_s2;
	logic        trim_s2;

	logic        adv_s2;
	logic        adv_s1;
	verdict_t    verdict;
	logic [5:0]  ip_bytes;
	logic [6:0]  tr_bytes;
	logic [6:0]  sum_bytes;
	logic [6:0]  tcp_pos;
	logic        keep;
	logic [16:0] cap_ext;

	assign adv_s2 = !valid_s2 || out_ready;
	assign adv_s1 = !valid_s1 || adv_s2;
	assign pop    = !empty && adv_s1;

	always_comb begin
		ip_bytes = {rec.ihl, 2'b00};
		tcp_pos  = TCP_OFF + {1'b0, ip_bytes};
		tr_bytes = '0;
		verdict  = VERDICT_KEEP;
		priority if (rec.cap <= ETH_BYTES) begin
			verdict = VERDICT_TRUNC;
		end else if (rec.ihl < MIN_WORDS) begin
			verdict = VERDICT_IP_SHORT;
		end else if (rec.cap < MIN_PROTO) begin
			verdict = VERDICT_TRUNC;
		end else if (rec.proto == PROTO_TCP) begin
			priority if (rec.cap <= {9'd0, tcp_pos}) begin
				verdict = VERDICT_TRUNC;
			end else if (rec.tcp < MIN_WORDS) begin
				verdict = VERDICT_TCP_SHORT;
			end else begin
				tr_bytes = {1'b0, rec.tcp, 2'b00};
			end
		end else if (rec.proto == PROTO_UDP) begin
			tr_bytes = UDP_BYTES;
		end else begin
			verdict = VERDICT_PROTO;
		end
		sum_bytes = {1'b0, ip_bytes} + tr_bytes;
		if (verdict == VERDICT_KEEP && rec.total <= {9'd0, sum_bytes}) begin
			verdict = VERDICT_NO_PAY;
		end
		keep = (verdict == VERDICT_KEEP);
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			verdict_s1 <= verdict;
			cap_s1     <= rec.cap;
			hdr_s1     <= keep ? ETH_BYTES[7:0] + {1'b0, sum_bytes} : '0;
			pay_s1     <= keep ? rec.total - {9'd0, sum_bytes} : '0;
			rest_s1    <= keep ? {1'b0, ETH_BYTES} + {1'b0, rec.total} : '0;
		end
	end

	assign cap_ext = {1'b0, cap_s1};

	always_ff @(posedge clk) begin
		if (valid_s1 && adv_s2) begin
			verdict_s2 <= verdict_s1;
			hdr_s2     <= hdr_s1;
			pay_s2     <= pay_s1;
			rest_s2    <= rest_s1;
			cap_s2     <= cap_s1;
			pad_s2     <= (verdict_s1 == VERDICT_KEEP && rest_s1 > cap_ext) ?
				rest_s1 - cap_ext : '0;
			trim_s2    <= (verdict_s1 == VERDICT_KEEP) && (rest_s1 < cap_ext);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= pop;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	assign out_valid = valid_s2;
	assign out_user  = verdict_s2;
	assign out_data  = {5'b00000, trim_s2, pad_s2, cap_s2, rest_s2, pay_s2, hdr_s2};

endmodule

[design/ipv4_l4_header_length_parser_core.sv]
// IPv4 L4 header-length parser top level: front end, record queue, back end.
// Depends on ihlp_pkg, ihlp_front, ihlp_fifo, ihlp_back.
// Throughput: one byte per cycle; the front end stalls only when the queue is full.
// After the last byte is taken, the result passes the queue write, then the verdict
// stage, then the output register, and is held back while m_tready is low.
// Reset: arst_n clears the byte count, captured fields, queue and stage valids.
module ipv4_l4_header_length_parser_core import ihlp_pkg::*; #(
	parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // data_byte
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	// header_len[7:0], payload_len[23:8], restored_len[40:24], captured_len[56:41],
	// pad_len[73:57], trim[74], zero[79:75]
	output logic [79:0] m_tdata,
	output logic [2:0]  m_tuser   // verdict
);

	frame_rec_t push_rec;
	frame_rec_t pop_rec;
	logic       push;
	logic       pop;
	logic       full;
	logic       empty;

	ihlp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_byte  (s_tdata),
		.in_last  (s_tlast),
		.push     (push),
		.push_rec (push_rec),
		.full     (full)
	);

	ihlp_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.full     (full),
		.pop      (pop),
		.pop_rec  (pop_rec),
		.empty    (empty)
	);

	ihlp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (empty),
		.rec       (pop_rec),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_user  (m_tuser)
	);

endmodule
